// ===== src/eight_bit_alu_with_flags_macros.svh =====
// Assertion macros used by the checker file.
`ifndef EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH
`define EIGHT_BIT_ALU_WITH_FLAGS_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define ALU8F_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alu8f check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset
`define ALU8F_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alu8f check failed");

`endif

// ===== src/alu8f_pkg.sv =====
package alu8f_pkg;

    // Operation codes
    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_XOR   = 5'd5,
        OP_OR    = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_DAA   = 5'd10,
        OP_CPL   = 5'd11,
        OP_RLCA  = 5'd12,
        OP_RLA   = 5'd13,
        OP_RRCA  = 5'd14,
        OP_RRA   = 5'd15,
        OP_RLC   = 5'd16,
        OP_RL    = 5'd17,
        OP_RRC   = 5'd18,
        OP_RR    = 5'd19,
        OP_SLA   = 5'd20,
        OP_SRA   = 5'd21,
        OP_SRL   = 5'd22,
        OP_SWAP  = 5'd23,
        OP_BIT   = 5'd24,
        OP_RES   = 5'd25,
        OP_SET   = 5'd26,
        OP_ADD16 = 5'd27,
        OP_ADDSP = 5'd28,
        OP_ADDRL = 5'd29
    } op_t;

    // Flag bit positions
    localparam int unsigned FLAG_Z = 3;
    localparam int unsigned FLAG_N = 2;
    localparam int unsigned FLAG_H = 1;
    localparam int unsigned FLAG_C = 0;

    // Stream widths
    localparam int unsigned IN_DATA_W  = 40;
    localparam int unsigned IN_USER_W  = 5;
    localparam int unsigned OUT_DATA_W = 24;

    // One ALU request
    typedef struct packed {
        op_t         op;
        logic [15:0] operand_a;
        logic [15:0] operand_b;
        logic [2:0]  bit_index;
        logic [3:0]  flags_in;
    } alu8f_req_t;

    // One ALU answer
    typedef struct packed {
        logic [15:0] result;
        logic [3:0]  flags_out;
    } alu8f_rsp_t;

endpackage

// ===== src/alu8f_core.sv =====
module alu8f_core (
    input  alu8f_pkg::alu8f_req_t req,
    output alu8f_pkg::alu8f_rsp_t rsp
);
    import alu8f_pkg::*;

    logic [7:0]  a;
    logic [7:0]  b;
    logic        cin;
    logic [15:0] sb;
    logic [8:0]  sum9;
    logic [8:0]  dif9;
    logic [7:0]  r8;
    logic [16:0] sum17;
    logic [15:0] rel16;
    logic [4:0]  nib5;
    logic        daa_lo;
    logic [8:0]  daa_t1;
    logic        daa_hi;
    logic [9:0]  daa_t2;
    logic [7:0]  daa_sub;
    logic [3:0]  f;
    logic [15:0] r;

    assign a   = req.operand_a[7:0];
    assign b   = req.operand_b[7:0];
    assign cin = req.flags_in[FLAG_C];
    assign sb  = {{8{b[7]}}, b};

    // Shared adders
    assign sum9  = {1'b0, a} + {1'b0, b}
                 + {8'd0, (req.op == OP_ADC) ? cin : 1'b0};
    assign dif9  = {1'b0, a} - {1'b0, b}
                 - {8'd0, (req.op == OP_SBC) ? cin : 1'b0};
    assign sum17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
    assign rel16 = req.operand_a + sb;
    assign nib5  = {1'b0, req.operand_a[3:0]} + {1'b0, b[3:0]};

    // Decimal adjust, addition side
    assign daa_lo = req.flags_in[FLAG_H] || (a[3:0] > 4'h9);
    assign daa_t1 = {1'b0, a} + (daa_lo ? 9'h006 : 9'h000);
    assign daa_hi = cin || (daa_t1 > 9'h09F);
    assign daa_t2 = {1'b0, daa_t1} + (daa_hi ? 10'h060 : 10'h000);
    // Decimal adjust, subtraction side
    assign daa_sub = a - (req.flags_in[FLAG_H] ? 8'h06 : 8'h00)
                       - (cin ? 8'h60 : 8'h00);

    always_comb
    begin
        r8 = 8'd0;
        r  = 16'd0;
        f  = req.flags_in;
        unique case (req.op)
            OP_ADD, OP_ADC:
            begin
                r8 = sum9[7:0];
                r  = {8'd0, r8};
                f  = {r8 == 8'd0, 1'b0, (a[4] ^ b[4] ^ sum9[4]), sum9[8]};
            end
            OP_SUB, OP_SBC, OP_CP:
            begin
                r8 = dif9[7:0];
                r  = (req.op == OP_CP) ? req.operand_a : {8'd0, r8};
                f  = {r8 == 8'd0, 1'b1, (a[4] ^ b[4] ^ dif9[4]), dif9[8]};
            end
            OP_AND:
            begin
                r8 = a & b;
                r  = {8'd0, r8};
                f  = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
            end
            OP_XOR:
            begin
                r8 = a ^ b;
                r  = {8'd0, r8};
                f  = {r8 == 8'd0, 3'b000};
            end
            OP_OR:
            begin
                r8 = a | b;
                r  = {8'd0, r8};
                f  = {r8 == 8'd0, 3'b000};
            end
            OP_INC:
            begin
                r8 = a + 8'd1;
                r  = {8'd0, r8};
                f  = {r8 == 8'd0, 1'b0, r8[3:0] == 4'h0, cin};
            end
            OP_DEC:
            begin
                r8 = a - 8'd1;
                r  = {8'd0, r8};
                f  = {r8 == 8'd0, 1'b1, r8[3:0] == 4'hF, cin};
            end
            OP_DAA:
            begin
                if (req.flags_in[FLAG_N])
                begin
                    r8 = daa_sub;
                    f  = {r8 == 8'd0, 1'b1, 1'b0, cin};
                end
                else
                begin
                    r8 = daa_t2[7:0];
                    f  = {r8 == 8'd0, 1'b0, 1'b0, cin | (daa_t2[9:8] != 2'b00)};
                end
                r = {8'd0, r8};
            end
            OP_CPL:
            begin
                r8 = ~a;
                r  = {8'd0, r8};
                f  = {req.flags_in[FLAG_Z], 1'b1, 1'b1, cin};
            end
            OP_RLCA, OP_RLC:
            begin
                r8 = {a[6:0], a[7]};
                r  = {8'd0, r8};
                f  = {(req.op == OP_RLC) && (r8 == 8'd0), 2'b00, a[7]};
            end
            OP_RLA, OP_RL:
            begin
                r8 = {a[6:0], cin};
                r  = {8'd0, r8};
                f  = {(req.op == OP_RL) && (r8 == 8'd0), 2'b00, a[7]};
            end
            OP_RRCA, OP_RRC:
            begin
                r8 = {a[0], a[7:1]};
                r  = {8'd0, r8};
                f  = {(req.op == OP_RRC) && (r8 == 8'd0), 2'b00, a[0]};
            end
            OP_RRA, OP_RR:
            begin
                r8 = {cin, a[7:1]};
                r  = {8'd0, r8};
                f  = {(req.op == OP_RR) && (r8 == 8'd0), 2'b00, a[0]};
            end
            OP_SLA:
            begin
                r8 = {a[6:0], 1'b0};
                r  = {8'd0, r8};
                f  = {r8 == 8'd0, 2'b00, a[7]};
            end
            OP_SRA:
            begin
                r8 = {a[7], a[7:1]};
                r  = {8'd0, r8};
                f  = {r8 == 8'd0, 2'b00, a[0]};
            end
            OP_SRL:
            begin
                r8 = {1'b0, a[7:1]};
                r  = {8'd0, r8};
                f  = {r8 == 8'd0, 2'b00, a[0]};
            end
            OP_SWAP:
            begin
                r8 = {a[3:0], a[7:4]};
                r  = {8'd0, r8};
                f  = {r8 == 8'd0, 3'b000};
            end
            OP_BIT:
            begin
                r = req.operand_a;
                f = {~a[req.bit_index], 1'b0, 1'b1, cin};
            end
            OP_RES:
            begin
                r8 = a;
                r8[req.bit_index] = 1'b0;
                r  = {8'd0, r8};
            end
            OP_SET:
            begin
                r8 = a;
                r8[req.bit_index] = 1'b1;
                r  = {8'd0, r8};
            end
            OP_ADD16:
            begin
                r = sum17[15:0];
                f = {req.flags_in[FLAG_Z], 1'b0,
                     (req.operand_a[12] ^ req.operand_b[12] ^ sum17[12]), sum17[16]};
            end
            OP_ADDSP:
            begin
                r = rel16;
                f = {2'b00, nib5[4], sum9[8]};
            end
            OP_ADDRL:
            begin
                r = rel16;
            end
            default:
            begin
                // unused codes: zero result, flags untouched
                r = 16'd0;
            end
        endcase
    end

    assign rsp.result    = r;
    assign rsp.flags_out = f;

endmodule

// ===== src/eight_bit_alu_with_flags.sv =====
// Channel   Dir  tdata (low bit up)                                   tuser
// s_axis    in   operand_a[15:0] operand_b[31:16] bit_index[34:32]    op[4:0]
//                flags_in[38:35], zero pad [39]
// m_axis    out  result[15:0] flags_out[19:16], zero pad [23:20]      -
//
// One request per clock sustained while m_axis is not stalled; each request
// passes the input register, then the result register, before m_axis_tvalid
// rises.
// Reset clears both valid bits only; payload registers are not reset.
// A stall on m_axis holds the result; the input register still takes one
// more request if it is empty, then s_axis_tready drops.
module eight_bit_alu_with_flags (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // operand_a, operand_b, bit_index, flags_in, zero pad
    input  logic [alu8f_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // op
    input  logic [alu8f_pkg::IN_USER_W-1:0]       s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // result, flags_out, zero pad
    output logic [alu8f_pkg::OUT_DATA_W-1:0]      m_axis_tdata
);
    import alu8f_pkg::*;

    alu8f_req_t req_reg;
    alu8f_req_t req_next;
    logic       req_valid_reg;
    logic       req_valid_next;
    alu8f_rsp_t rsp;
    alu8f_rsp_t out_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       s_accept;
    logic       out_advance;

    // Handshake control
    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !req_valid_reg || out_advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    // Unpack the incoming request
    always_comb
    begin
        req_next.op        = op_t'(s_axis_tuser);
        req_next.operand_a = s_axis_tdata[15:0];
        req_next.operand_b = s_axis_tdata[31:16];
        req_next.bit_index = s_axis_tdata[34:32];
        req_next.flags_in  = s_axis_tdata[38:35];
    end

    // Valid bits next state
    always_comb
    begin
        if (s_accept)
            req_valid_next = 1'b1;
        else if (out_advance)
            req_valid_next = 1'b0;
        else
            req_valid_next = req_valid_reg;
        out_valid_next = out_advance ? req_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_accept)
            req_reg <= req_next;
        if (out_advance && req_valid_reg)
            out_reg <= rsp;
    end

    alu8f_core u_core (
        .req (req_reg),
        .rsp (rsp)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0, out_reg.flags_out, out_reg.result};

endmodule

// ===== src/alu8f_checker.sv =====
`include "eight_bit_alu_with_flags_macros.svh"

module alu8f_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [alu8f_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input logic [alu8f_pkg::IN_USER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [alu8f_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import alu8f_pkg::*;

    logic m_stall;
    logic s_accept;

    assign m_stall  = m_axis_tvalid && !m_axis_tready;
    assign s_accept = s_axis_tvalid && s_axis_tready;

    // A stalled result stays offered and unchanged
    `ALU8F_ASSERT_NXT(a_out_hold, clk, rst_n, m_stall, m_axis_tvalid)
    `ALU8F_ASSERT_NXT(a_out_stable, clk, rst_n, m_stall, $stable(m_axis_tdata))
    // Back-pressure only comes from a stalled output
    `ALU8F_ASSERT_IMP(a_ready_cause, clk, rst_n, !s_axis_tready, m_stall)
    // Each accepted request is followed by m_axis_tvalid high, after the input and result registers
    `ALU8F_ASSERT_NXT(a_latency, clk, rst_n, s_accept, ##1 m_axis_tvalid)

endmodule

bind eight_bit_alu_with_flags alu8f_checker u_checker (.*);
